/* rtl/core/ufpc_pkg.sv */
package ufpc_pkg;

  // Fixed field widths
  localparam int END_W   = 10;
  localparam int COUNT_W = 19;

  // Largest value the pair_count field can show
  localparam logic [COUNT_W-1:0] PAIR_COUNT_MAX = '1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_COMP,
    S_SZ_A,
    S_SZ_B,
    S_MUL_A,
    S_MUL_B,
    S_MUL_J,
    S_LINK,
    S_ZERO,
    S_DONE
  } state_t;

endpackage

/* rtl/core/union_find_pair_counter.sv */
// Disjoint-set engine with a running count of connected node pairs. Each input
// item is one edge; the block walks parent links to both roots, compresses both
// paths, links the smaller set under the larger (first root under the second on
// a tie) and returns the new pair count with a merged flag. After reset the
// block sweeps its tables (MAX_NODES entries, 1024 by default) with in_ready
// low. Every link is one read of the parent table, the sizes are two reads of
// the size table, and one shared multiplier forms the three s*(s-1)/2 terms in
// turn. An edge with an end out of range skips the walk and returns the count
// unchanged with the merged flag low. The result sits in an output register,
// so the next edge is taken while it waits; that edge then holds in its final
// state until the waiting result is taken.
module union_find_pair_counter
  import ufpc_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [END_W-1:0]   edge_end_a,
  input  logic [END_W-1:0]   edge_end_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] pair_count,
  output logic               sets_merged
);

  localparam int NODE_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int SIZE_W = $clog2(MAX_NODES + 1);
  localparam int PT_W   = 2 * SIZE_W;
  localparam int EXT_W  = (NODE_W > END_W) ? NODE_W : END_W;
  localparam int SAT_W  = (PT_W > COUNT_W) ? PT_W : COUNT_W;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

  // Tables
  logic [NODE_W-1:0] parent_mem [MAX_NODES];
  logic [SIZE_W-1:0] size_mem   [MAX_NODES];

  logic [NODE_W-1:0] parent_raddr, parent_waddr, parent_wdata, parent_rd;
  logic              parent_we;
  logic [NODE_W-1:0] size_raddr, size_waddr;
  logic [SIZE_W-1:0] size_wdata, size_rd;
  logic              size_we;

  state_t state, state_next;

  logic [NODE_W-1:0] clr_idx;
  logic [NODE_W-1:0] node_a, node_b, cur, root_a, root_b;
  logic              side;
  logic [SIZE_W-1:0] sa, sb, joined;
  logic [PT_W-1:0]   prod, total;
  logic              merged;

  logic [EXT_W-1:0]  a_ext, b_ext;
  logic [NODE_W-1:0] a_node, b_node;
  logic              in_range;
  logic [NODE_W-1:0] side_node, side_root;
  logic              a_wins;
  logic [SIZE_W-1:0] mul_op;
  logic [PT_W-1:0]   mul_pairs;
  logic [SAT_W-1:0]  total_w;
  logic              out_free;

  assign a_ext    = EXT_W'(edge_end_a);
  assign b_ext    = EXT_W'(edge_end_b);
  assign a_node   = a_ext[NODE_W-1:0];
  assign b_node   = b_ext[NODE_W-1:0];
  assign in_range = (32'(edge_end_a) < MAX_NODES) && (32'(edge_end_b) < MAX_NODES);

  assign side_node = side ? node_b : node_a;
  assign side_root = side ? root_b : root_a;
  assign a_wins    = sa > sb;
  assign out_free  = !out_valid || out_ready;
  assign total_w   = SAT_W'(total);

  // s*(s-1)/2 on the shared multiplier
  function automatic logic [PT_W-1:0] pairs_of(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] sm1;
    logic [PT_W-1:0]   p;
    sm1 = (s == '0) ? '0 : s - 1'b1;
    p   = PT_W'(s) * PT_W'(sm1);
    return p >> 1;
  endfunction

  assign mul_pairs = pairs_of(mul_op);

  // Memories: one write and one registered read per table
  always_ff @(posedge clk) begin
    if (parent_we) begin
      parent_mem[parent_waddr] <= parent_wdata;
    end
    parent_rd <= parent_mem[parent_raddr];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_rd <= size_mem[size_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == LAST_NODE) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_next = in_range ? S_FIND : S_DONE;
      end
      S_FIND: if (parent_rd == cur) state_next = S_COMP;
      S_COMP: begin
        if (cur == side_root) begin
          if (!side)                 state_next = S_FIND;
          else if (root_a == root_b) state_next = S_DONE;
          else                       state_next = S_SZ_A;
        end
      end
      S_SZ_A:  state_next = S_SZ_B;
      S_SZ_B:  state_next = S_MUL_A;
      S_MUL_A: state_next = S_MUL_B;
      S_MUL_B: state_next = S_MUL_J;
      S_MUL_J: state_next = S_LINK;
      S_LINK:  state_next = S_ZERO;
      S_ZERO:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    in_ready     = 1'b0;
    parent_raddr = cur;
    parent_waddr = cur;
    parent_wdata = side_root;
    parent_we    = 1'b0;
    size_raddr   = root_a;
    size_waddr   = root_a;
    size_wdata   = joined;
    size_we      = 1'b0;
    mul_op       = sa;
    unique case (state)
      S_CLEAR: begin
        parent_waddr = clr_idx;
        parent_wdata = clr_idx;
        parent_we    = 1'b1;
        size_waddr   = clr_idx;
        size_wdata   = SIZE_W'(1);
        size_we      = 1'b1;
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        parent_raddr = a_node;
      end
      S_FIND: begin
        // keep walking, or restart at the end node for compression
        parent_raddr = (parent_rd == cur) ? side_node : parent_rd;
      end
      S_COMP: begin
        if (cur == side_root) begin
          parent_raddr = node_b;
        end else begin
          parent_raddr = parent_rd;
          parent_we    = 1'b1;
        end
      end
      S_SZ_A:  size_raddr = root_a;
      S_SZ_B:  size_raddr = root_b;
      S_MUL_A: mul_op = sa;
      S_MUL_B: mul_op = sb;
      S_MUL_J: mul_op = joined;
      S_LINK: begin
        parent_we    = 1'b1;
        parent_waddr = a_wins ? root_b : root_a;
        parent_wdata = a_wins ? root_a : root_b;
        size_we      = 1'b1;
        size_waddr   = a_wins ? root_a : root_b;
        size_wdata   = joined;
      end
      S_ZERO: begin
        size_we    = 1'b1;
        size_waddr = a_wins ? root_b : root_a;
        size_wdata = '0;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      // result register: filled on the way out, emptied when taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_MUL_B, S_MUL_J: total <= total - prod;
        S_LINK:           total <= total + prod;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        node_a <= a_node;
        node_b <= b_node;
        cur    <= a_node;
        side   <= 1'b0;
        merged <= 1'b0;
      end
      S_FIND: begin
        if (parent_rd == cur) begin
          if (side) root_b <= cur;
          else      root_a <= cur;
          cur <= side_node;
        end else begin
          cur <= parent_rd;
        end
      end
      S_COMP: begin
        if (cur == side_root) begin
          side <= 1'b1;
          cur  <= node_b;
        end else begin
          cur <= parent_rd;
        end
      end
      S_SZ_B:  sa <= size_rd;
      S_MUL_A: begin
        sb     <= size_rd;
        joined <= sa + size_rd;
        prod   <= mul_pairs;
      end
      S_MUL_B, S_MUL_J: prod <= mul_pairs;
      S_LINK:  merged <= 1'b1;
      S_DONE: begin
        if (out_free) begin
          pair_count  <= (total_w > SAT_W'(PAIR_COUNT_MAX)) ? PAIR_COUNT_MAX
                                                            : total_w[COUNT_W-1:0];
          sets_merged <= merged;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/ufpc_checker.sv */
module ufpc_assertions
  import ufpc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [END_W-1:0]   edge_end_a,
  input logic [END_W-1:0]   edge_end_b,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] pair_count,
  input logic               sets_merged
);

  logic [COUNT_W-1:0] last_count;
  logic               out_take;

  assign out_take = out_valid && out_ready;

  // count of the last result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (out_take) begin
      last_count <= pair_count;
    end
  end

  // the table sweep keeps the block closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block open right after reset");

  // a waiting edge holds its ends
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(edge_end_a) && $stable(edge_end_b))
    else $error("edge changed while waiting");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pair_count) && $stable(sets_merged))
    else $error("result changed while stalled");

  // no merge leaves the count where it was
  a_no_merge_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sets_merged |-> pair_count == last_count)
    else $error("count moved without a merge");

  // a merge always adds pairs unless the count is pinned at its limit
  a_merge_grows: assert property (@(posedge clk) disable iff (rst)
    out_valid && sets_merged |-> pair_count > last_count || last_count == PAIR_COUNT_MAX)
    else $error("merge did not raise the count");

endmodule

bind union_find_pair_counter ufpc_assertions u_ufpc_checker (.*);
